[src/rkbd_pkg.sv]
`timescale 1ns / 1ps

package rkbd_pkg;

    localparam int KEY_DEPTH = 256;
    localparam int KEY_AW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;

    localparam logic KIND_KEY  = 1'b0;
    localparam logic KIND_DATA = 1'b1;

    typedef struct packed {
        logic              en;
        logic [KEY_AW-1:0] addr;
        logic [7:0]        data;
    } key_wr_t;

endpackage

[src/rolling_key_byte_decrypt.sv]
`timescale 1ns / 1ps

// Rolling-key byte decryptor. Each input word is either a key byte (kind 0), which is
// stored at key_position and restarts the stream, or a cipher byte (kind 1), which
// yields plain_byte = byte_value - (key[pointer] + offset) mod 256 on the next cycle in
// the output register. One word is taken every clock, held back only when the output
// register is full and out_ready is low; the key store is prefetched at the next
// pointer so its registered read port keeps that pace. Writing key_length (0 is taken
// as 1) restarts the stream too; the user must do so with no word in flight (unenforced).
module rolling_key_byte_decrypt
    import rkbd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write,
    input  logic [7:0] cfg_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       kind,
    input  logic [7:0] key_position,
    input  logic [7:0] byte_value,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] plain_byte
);

    logic [7:0] key_length_reg, key_length_next;
    logic [7:0] ptr_reg, ptr_next;
    logic [7:0] limit_reg, limit_next;
    logic [7:0] offset_reg, offset_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] plain_reg, plain_next;

    logic       in_fire;
    logic       key_fire;
    logic       data_fire;
    logic [7:0] ptr_inc;
    logic [7:0] key_byte;
    logic [7:0] key_raw;
    logic       ptr_in_range;
    key_wr_t    key_wr;

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;
    assign key_fire  = in_fire && (kind == KIND_KEY);
    assign data_fire = in_fire && (kind == KIND_DATA);

    assign key_wr.en   = key_fire && ({1'b0, key_position} < 9'(KEY_DEPTH));
    assign key_wr.addr = key_position[KEY_AW-1:0];
    assign key_wr.data = byte_value;

    rkbd_key_mem u_key_mem (
        .clk     (clk),
        .wr      (key_wr),
        .rd_addr (ptr_next[KEY_AW-1:0]),
        .rd_data (key_raw)
    );

    assign ptr_in_range = ({1'b0, ptr_reg} < 9'(KEY_DEPTH));
    assign key_byte     = ptr_in_range ? key_raw : 8'd0;
    assign ptr_inc      = ptr_reg + 8'd1;

    always_comb
    begin
        key_length_next = key_length_reg;
        ptr_next        = ptr_reg;
        limit_next      = limit_reg;
        offset_next     = offset_reg;
        if (cfg_write)
        begin
            key_length_next = (cfg_data == 8'd0) ? 8'd1 : cfg_data;
            ptr_next        = 8'd0;
            limit_next      = key_length_next;
            offset_next     = 8'd0;
        end
        else if (key_fire)
        begin
            ptr_next    = 8'd0;
            limit_next  = key_length_reg;
            offset_next = 8'd0;
        end
        else if (data_fire)
        begin
            if (ptr_inc == limit_reg)
            begin
                ptr_next    = 8'd0;
                offset_next = offset_reg + key_length_reg;
                limit_next  = (limit_reg == 8'd1) ? key_length_reg : limit_reg - 8'd1;
            end
            else
            begin
                ptr_next = ptr_inc;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        plain_next     = plain_reg;
        if (in_ready)
        begin
            out_valid_next = data_fire;
        end
        if (data_fire)
        begin
            plain_next = byte_value - (key_byte + offset_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_length_reg <= 8'd1;
            ptr_reg        <= 8'd0;
            limit_reg      <= 8'd1;
            offset_reg     <= 8'd0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            key_length_reg <= key_length_next;
            ptr_reg        <= ptr_next;
            limit_reg      <= limit_next;
            offset_reg     <= offset_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        plain_reg <= plain_next;
    end

    assign out_valid  = out_valid_reg;
    assign plain_byte = plain_reg;

    // pointer stays inside the current pass
    a_ptr_below_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (limit_reg != 8'd0) && (ptr_reg < limit_reg))
        else $error("key pointer outside pass limit");

    a_key_restart: assert property (@(posedge clk) disable iff (!rst_n)
        key_fire && !cfg_write |=> (ptr_reg == 8'd0) && (offset_reg == 8'd0)
            && (limit_reg == key_length_reg))
        else $error("key word did not restart stream");

    a_data_result: assert property (@(posedge clk) disable iff (!rst_n)
        data_fire |=> out_valid_reg)
        else $error("data word produced no result");

    a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        key_length_reg != 8'd0)
        else $error("key length is zero");

endmodule

[src/rkbd_key_mem.sv]
`timescale 1ns / 1ps

module rkbd_key_mem
    import rkbd_pkg::*;
(
    input  logic              clk,
    input  key_wr_t           wr,
    input  logic [KEY_AW-1:0] rd_addr,
    output logic [7:0]        rd_data
);

    logic [7:0] mem_reg [KEY_DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem_reg[wr.addr] <= wr.data;
        end
    end

    // same-cycle write to the read address forwards the new byte
    always_ff @(posedge clk)
    begin
        if (wr.en && (wr.addr == rd_addr))
        begin
            rd_data_reg <= wr.data;
        end
        else
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps

module tb;
    import rkbd_pkg::*;

    localparam int TIMEOUT_CYCLES = 400000;
    localparam int SETTLE_CYCLES = 4;
    localparam int NUM_PHASES = 10;
    localparam int NUM_ROWS = 17;

    typedef struct packed {
        logic       kind;
        logic [7:0] pos;
        logic [7:0] val;
        logic       typed;
        logic [7:0] plain;
    } stim_row_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_write;
    logic [7:0] cfg_data;
    logic       in_valid;
    logic       in_ready;
    logic       kind;
    logic [7:0] key_position;
    logic [7:0] byte_value;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] plain_byte;

    logic [7:0] key_mem [KEY_DEPTH];
    logic [7:0] stream_ptr;
    logic [7:0] pass_lim;
    logic [7:0] stream_offs;
    logic [7:0] key_len;
    logic [7:0] plain_q [$];
    logic [7:0] want_plain;

    int fail_count = 0;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int stall_pct = 0;

    // typed expectations only right after a key write (offset 0)
    stim_row_t seq_rows [NUM_ROWS] = '{
        '{KIND_KEY,  8'h00, 8'hff, 1'b0, 8'h00},
        '{KIND_DATA, 8'h00, 8'h00, 1'b1, 8'h01},
        '{KIND_DATA, 8'hff, 8'hff, 1'b0, 8'h00},
        '{KIND_DATA, 8'h12, 8'h80, 1'b0, 8'h00},
        '{KIND_KEY,  8'hfe, 8'h5a, 1'b0, 8'h00},
        '{KIND_KEY,  8'h00, 8'h00, 1'b0, 8'h00},
        '{KIND_DATA, 8'haa, 8'hff, 1'b1, 8'hff},
        '{KIND_DATA, 8'h55, 8'h00, 1'b0, 8'h00},
        '{KIND_KEY,  8'h55, 8'haa, 1'b0, 8'h00},
        '{KIND_KEY,  8'haa, 8'h55, 1'b0, 8'h00},
        '{KIND_KEY,  8'h00, 8'h55, 1'b0, 8'h00},
        '{KIND_DATA, 8'h00, 8'h55, 1'b1, 8'h00},
        '{KIND_DATA, 8'hfe, 8'haa, 1'b0, 8'h00},
        '{KIND_KEY,  8'h00, 8'h01, 1'b0, 8'h00},
        '{KIND_DATA, 8'h01, 8'h00, 1'b1, 8'hff},
        '{KIND_DATA, 8'h80, 8'h7f, 1'b0, 8'h00},
        '{KIND_DATA, 8'h7f, 8'h01, 1'b0, 8'h00}
    };

    rolling_key_byte_decrypt dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .key_position (key_position),
        .byte_value   (byte_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .plain_byte   (plain_byte)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic void restart_keystream();
        stream_ptr = 8'd0;
        pass_lim = key_len;
        stream_offs = 8'd0;
    endfunction

    function automatic logic predict_plain(input logic k, input logic [7:0] pos,
                                           input logic [7:0] val,
                                           output logic [7:0] plain);
        plain = 8'd0;
        if (k == KIND_KEY)
        begin
            key_mem[pos] = val;
            restart_keystream();
            return 1'b0;
        end
        plain = val - (key_mem[stream_ptr] + stream_offs);
        stream_ptr = stream_ptr + 8'd1;
        if (stream_ptr == pass_lim)
        begin
            stream_ptr = 8'd0;
            stream_offs = stream_offs + key_len;
            pass_lim = pass_lim - 8'd1;
            if (pass_lim == 8'd0)
                pass_lim = key_len;
        end
        return 1'b1;
    endfunction

    task automatic send_word(input logic k, input logic [7:0] pos, input logic [7:0] val,
                             input logic typed, input logic [7:0] typed_plain);
        logic [7:0] plain;
        logic       has_plain;
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        kind = k;
        key_position = pos;
        byte_value = val;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        has_plain = predict_plain(k, pos, val, plain);
        if (has_plain)
            plain_q.push_back(typed ? typed_plain : plain);
    endtask

    task automatic drain_stream();
        @(negedge clk);
        in_valid = 1'b0;
        while (plain_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_key_length(input logic [7:0] v);
        @(negedge clk);
        cfg_write = 1'b1;
        cfg_data = v;
        @(negedge clk);
        cfg_write = 1'b0;
        key_len = (v == 8'd0) ? 8'd1 : v;
        restart_keystream();
    endtask

    always @(negedge clk)
        out_ready = ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (plain_q.size() == 0)
            begin
                $error("plain_byte: expected none, actual %0h", plain_byte);
                fail_count++;
            end
            else
            begin
                want_plain = plain_q.pop_front();
                if (plain_byte !== want_plain)
                begin
                    $error("plain_byte: expected %0h, actual %0h", want_plain, plain_byte);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > TIMEOUT_CYCLES)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial
    begin
        int         len_sel;
        int         word_cnt;
        logic [7:0] len_val;
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_data = 8'd0;
        in_valid = 1'b0;
        kind = KIND_KEY;
        key_position = 8'd0;
        byte_value = 8'd0;
        out_ready = 1'b0;
        key_len = 8'd1;
        restart_keystream();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < NUM_ROWS; i++)
            send_word(seq_rows[i].kind, seq_rows[i].pos, seq_rows[i].val,
                      seq_rows[i].typed, seq_rows[i].plain);
        drain_stream();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 49; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 49; end
                default: begin send_idle_pct = 15; stall_pct = 15; end
            endcase
            case (p)
                0: len_val = 8'd0;
                1: len_val = 8'd1;
                2: len_val = 8'd2;
                3: len_val = 8'd3;
                4: len_val = 8'd255;
                5: len_val = 8'd7;
                6: len_val = 8'($urandom_range(4, 32));
                7: len_val = 8'd16;
                8: len_val = 8'd5;
                default: len_val = 8'($urandom_range(4, 64));
            endcase
            write_key_length(len_val);
            len_sel = int'(key_len);
            for (int k = 0; k < len_sel; k++)
                send_word(KIND_KEY, 8'(k), 8'($urandom_range(255)), 1'b0, 8'd0);
            word_cnt = (2 * len_sel + 10 > 70) ? 2 * len_sel + 10 : 70;
            for (int j = 0; j < word_cnt; j++)
            begin
                // occasional key rewrite restarts the stream mid-flight
                if ($urandom_range(99) < 3)
                    send_word(KIND_KEY, 8'($urandom_range(254)), 8'($urandom_range(255)),
                              1'b0, 8'd0);
                send_word(KIND_DATA, 8'($urandom_range(255)), 8'($urandom_range(255)),
                          1'b0, 8'd0);
            end
            drain_stream();
        end

        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
